// ----- sv/iermatch_pkg.sv -----
package iermatch_pkg;

    localparam int MAX_PACKET_BYTES = 2048;
    localparam int IDX_W            = 12;
    localparam int IDX_LIMIT_INT    = (MAX_PACKET_BYTES > 4095) ? 4095 : MAX_PACKET_BYTES;
    localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_LIMIT_INT[IDX_W-1:0];

    localparam logic [7:0] TYPE_V4_TIME_EXCEEDED = 8'd11;
    localparam logic [7:0] TYPE_V4_UNREACH       = 8'd3;
    localparam logic [7:0] CODE_V4_PORT_UNREACH  = 8'd3;
    localparam logic [7:0] TYPE_V6_TIME_EXCEEDED = 8'd3;
    localparam logic [7:0] TYPE_V6_UNREACH       = 8'd1;
    localparam logic [7:0] ICMP_HDR_BYTES        = 8'd8;
    localparam logic [7:0] IPV6_HDR_BYTES        = 8'd40;

    typedef enum logic [1:0] {
        CFG_IP_VERSION_SIX    = 2'd0,
        CFG_PROBE_SOURCE_PORT = 2'd1,
        CFG_PROBE_DEST_PORT   = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        KIND_OTHER         = 2'd0,
        KIND_TIME_EXCEEDED = 2'd1,
        KIND_PORT_UNREACH  = 2'd2
    } t_reply_kind;

    typedef struct packed {
        logic [7:0]  icmp_type;
        logic [7:0]  icmp_code;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic        complete;
    } t_capture;

    function automatic t_reply_kind classify(input logic v6, input logic [7:0] icmp_type,
                                             input logic [7:0] icmp_code);
        t_reply_kind kind;
        kind = KIND_OTHER;
        if (v6) begin
            if (icmp_type == TYPE_V6_TIME_EXCEEDED) begin
                kind = KIND_TIME_EXCEEDED;
            end else if (icmp_type == TYPE_V6_UNREACH) begin
                kind = KIND_PORT_UNREACH;
            end
        end else begin
            if (icmp_type == TYPE_V4_TIME_EXCEEDED && icmp_code == 8'd0) begin
                kind = KIND_TIME_EXCEEDED;
            end else if (icmp_type == TYPE_V4_UNREACH && icmp_code == CODE_V4_PORT_UNREACH) begin
                kind = KIND_PORT_UNREACH;
            end
        end
        return kind;
    endfunction

endpackage

// ----- sv/icmp_error_reply_matcher_core.sv -----
// Takes one reply byte per cycle; a new word is accepted every cycle while the
// result register is free or being drained.
// The result is registered and appears on o_out_valid in the cycle after the final byte is accepted.
// Throughput: one byte per cycle, bounded by the single result register.
// Synchronous active-low reset clears the configuration registers to zero, the
// packet parse state and the result valid flag.
module icmp_error_reply_matcher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_end_of_packet,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_port_match,
    output logic [1:0]  o_reply_kind,
    output logic [7:0]  o_icmp_type_seen,
    output logic [7:0]  o_icmp_code_seen,
    output logic        o_truncated
);
    import iermatch_pkg::*;

    logic        r_ip_version_six;
    logic [15:0] r_probe_source_port;
    logic [15:0] r_probe_dest_port;

    logic        r_out_valid;
    logic        r_port_match;
    t_reply_kind r_reply_kind;
    logic [7:0]  r_icmp_type;
    logic [7:0]  r_icmp_code;
    logic        r_truncated;

    logic        in_accept;
    logic        result_load;
    t_capture    cap;
    logic [15:0] want_dst;
    logic        n_port_match;
    t_reply_kind n_reply_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ip_version_six    <= 1'b0;
            r_probe_source_port <= '0;
            r_probe_dest_port   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_IP_VERSION_SIX:    r_ip_version_six    <= i_cfg_data[0];
                CFG_PROBE_SOURCE_PORT: r_probe_source_port <= i_cfg_data;
                CFG_PROBE_DEST_PORT:   r_probe_dest_port   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // hold input while a finished result is stuck downstream
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign result_load = in_accept && i_end_of_packet;

    iermatch_parse u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_rx_byte      (i_rx_byte),
        .i_end_of_packet(i_end_of_packet),
        .i_v6           (r_ip_version_six),
        .o_cap          (cap)
    );

    always_comb begin
        want_dst     = r_probe_dest_port - 16'd1;
        n_port_match = cap.complete && (cap.src_port == r_probe_source_port)
                       && (cap.dst_port == want_dst);
        n_reply_kind = classify(r_ip_version_six, cap.icmp_type, cap.icmp_code);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (result_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result_load) begin
            r_port_match <= n_port_match;
            r_reply_kind <= n_reply_kind;
            r_icmp_type  <= cap.icmp_type;
            r_icmp_code  <= cap.icmp_code;
            r_truncated  <= !cap.complete;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_port_match     = r_port_match;
    assign o_reply_kind     = r_reply_kind;
    assign o_icmp_type_seen = r_icmp_type;
    assign o_icmp_code_seen = r_icmp_code;
    assign o_truncated      = r_truncated;

endmodule

// ----- sv/iermatch_parse.sv -----
module iermatch_parse (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic [7:0]             i_rx_byte,
    input  logic                   i_end_of_packet,
    input  logic                   i_v6,
    output iermatch_pkg::t_capture o_cap
);
    import iermatch_pkg::*;

    logic [IDX_W-1:0] r_byte_index;
    logic [5:0]       r_icmp_start;
    logic [7:0]       r_udp_start;
    t_capture         r_cap;

    logic [IDX_W-1:0] n_byte_index;
    logic [5:0]       n_icmp_start;
    logic [7:0]       n_udp_start;
    t_capture         n_cap;

    logic             in_range;
    logic [5:0]       ic;
    logic [IDX_W-1:0] ic_ext;
    logic [IDX_W-1:0] hdr_end;
    logic [7:0]       us;
    logic [IDX_W-1:0] us_ext;
    logic             ports_known;

    always_comb begin
        in_range     = (r_byte_index < IDX_LIMIT);
        n_byte_index = r_byte_index;
        n_icmp_start = r_icmp_start;
        n_udp_start  = r_udp_start;
        n_cap        = r_cap;

        // outer IPv4 header length locates the ICMP header
        if (in_range && !i_v6 && r_byte_index == '0) begin
            n_icmp_start = {i_rx_byte[3:0], 2'b00};
        end
        ic      = i_v6 ? 6'd0 : n_icmp_start;
        ic_ext  = {{(IDX_W-6){1'b0}}, ic};
        hdr_end = ic_ext + {{(IDX_W-8){1'b0}}, ICMP_HDR_BYTES};

        // quoted inner header length locates the UDP ports
        if (in_range && !i_v6 && r_byte_index == hdr_end) begin
            n_udp_start = {2'b00, ic} + ICMP_HDR_BYTES + {2'b00, i_rx_byte[3:0], 2'b00};
        end
        us          = i_v6 ? (ICMP_HDR_BYTES + IPV6_HDR_BYTES) : n_udp_start;
        us_ext      = {{(IDX_W-8){1'b0}}, us};
        ports_known = i_v6 || (r_byte_index >= hdr_end);

        if (in_range) begin
            n_byte_index = r_byte_index + 12'd1;
            if (r_byte_index == ic_ext) begin
                n_cap.icmp_type = i_rx_byte;
            end
            if (r_byte_index == ic_ext + 12'd1) begin
                n_cap.icmp_code = i_rx_byte;
            end
            if (ports_known) begin
                if (r_byte_index == us_ext) begin
                    n_cap.src_port[15:8] = i_rx_byte;
                end else if (r_byte_index == us_ext + 12'd1) begin
                    n_cap.src_port[7:0] = i_rx_byte;
                end else if (r_byte_index == us_ext + 12'd2) begin
                    n_cap.dst_port[15:8] = i_rx_byte;
                end else if (r_byte_index == us_ext + 12'd3) begin
                    n_cap.dst_port[7:0] = i_rx_byte;
                    n_cap.complete      = 1'b1;
                end
            end
        end
    end

    assign o_cap = n_cap;

    // clear everything after the final byte so the next reply starts fresh
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= '0;
            r_icmp_start <= '0;
            r_udp_start  <= '0;
            r_cap        <= '0;
        end else if (i_accept) begin
            if (i_end_of_packet) begin
                r_byte_index <= '0;
                r_icmp_start <= '0;
                r_udp_start  <= '0;
                r_cap        <= '0;
            end else begin
                r_byte_index <= n_byte_index;
                r_icmp_start <= n_icmp_start;
                r_udp_start  <= n_udp_start;
                r_cap        <= n_cap;
            end
        end
    end

endmodule

// ----- tb/sv/icmp_error_reply_matcher_core_tb.sv -----
`timescale 1ns / 100ps

module icmp_error_reply_matcher_core_tb;
    import iermatch_pkg::*;

    typedef struct {
        logic        match;
        t_reply_kind kind;
        logic [7:0]  typ;
        logic [7:0]  code;
        logic        trunc;
    } t_reply_verdict;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic [1:0]  i_cfg_index     = CFG_IP_VERSION_SIX;
    logic [15:0] i_cfg_data      = 16'h0000;
    logic        i_in_valid      = 1'b0;
    logic [7:0]  i_rx_byte       = 8'h00;
    logic        i_end_of_packet = 1'b0;
    logic        i_out_stall     = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_port_match;
    logic [1:0]  o_reply_kind;
    logic [7:0]  o_icmp_type_seen;
    logic [7:0]  o_icmp_code_seen;
    logic        o_truncated;

    // configuration as the block should hold it
    logic        cfg_v6;
    logic [15:0] cfg_src_port;
    logic [15:0] cfg_dst_port;

    // parse state of the reply in flight
    logic [IDX_W-1:0] rx_pos;
    logic [5:0]       hdr_off;
    logic [7:0]       udp_off;
    logic [7:0]       cap_type;
    logic [7:0]       cap_code;
    logic [15:0]      cap_src;
    logic [15:0]      cap_dst;
    logic             ports_done;

    t_reply_verdict expected_replies[$];
    logic [7:0]     frame[$];

    bit quiet = 1'b0;
    int error_count    = 0;
    int bytes_sent     = 0;
    int replies_seen   = 0;
    int matches_seen   = 0;
    int truncs_seen    = 0;

    icmp_error_reply_matcher_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_rx_byte        (i_rx_byte),
        .i_end_of_packet  (i_end_of_packet),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_port_match     (o_port_match),
        .o_reply_kind     (o_reply_kind),
        .o_icmp_type_seen (o_icmp_type_seen),
        .o_icmp_code_seen (o_icmp_code_seen),
        .o_truncated      (o_truncated)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void clear_parse();
        rx_pos     = '0;
        hdr_off    = '0;
        udp_off    = '0;
        cap_type   = '0;
        cap_code   = '0;
        cap_src    = '0;
        cap_dst    = '0;
        ports_done = 1'b0;
    endfunction

    function automatic void track_reply_byte(input logic [7:0] b, input logic last);
        int             idx;
        int             ic;
        int             us;
        bit             ports_known;
        t_reply_verdict v;
        logic [15:0]    want_dst;
        if (rx_pos < IDX_LIMIT) begin
            idx = int'(rx_pos);
            if (!cfg_v6 && idx == 0)
                hdr_off = {b[3:0], 2'b00};
            ic = cfg_v6 ? 0 : int'(hdr_off);
            if (idx == ic) cap_type = b;
            if (idx == ic + 1) cap_code = b;
            if (cfg_v6) begin
                us = int'(ICMP_HDR_BYTES) + int'(IPV6_HDR_BYTES);
                ports_known = 1'b1;
            end else begin
                // inner header length nibble sits right after the ICMP header
                if (idx == ic + int'(ICMP_HDR_BYTES))
                    udp_off = 8'(ic + int'(ICMP_HDR_BYTES) + 4 * int'(b[3:0]));
                us = int'(udp_off);
                ports_known = idx >= ic + int'(ICMP_HDR_BYTES);
            end
            if (ports_known) begin
                if (idx == us) begin
                    cap_src[15:8] = b;
                end else if (idx == us + 1) begin
                    cap_src[7:0] = b;
                end else if (idx == us + 2) begin
                    cap_dst[15:8] = b;
                end else if (idx == us + 3) begin
                    cap_dst[7:0] = b;
                    ports_done = 1'b1;
                end
            end
            rx_pos = rx_pos + 12'd1;
        end
        if (last) begin
            want_dst = cfg_dst_port - 16'd1;
            v.match  = ports_done && cap_src == cfg_src_port && cap_dst == want_dst;
            v.kind   = KIND_OTHER;
            if (cfg_v6) begin
                if (cap_type == TYPE_V6_TIME_EXCEEDED) begin
                    v.kind = KIND_TIME_EXCEEDED;
                end else if (cap_type == TYPE_V6_UNREACH) begin
                    v.kind = KIND_PORT_UNREACH;
                end
            end else begin
                if (cap_type == TYPE_V4_TIME_EXCEEDED && cap_code == 8'd0) begin
                    v.kind = KIND_TIME_EXCEEDED;
                end else if (cap_type == TYPE_V4_UNREACH &&
                             cap_code == CODE_V4_PORT_UNREACH) begin
                    v.kind = KIND_PORT_UNREACH;
                end
            end
            v.typ   = cap_type;
            v.code  = cap_code;
            v.trunc = !ports_done;
            expected_replies.push_back(v);
            clear_parse();
        end
    endfunction

    // result side: random stall, compare each accepted word against the oldest verdict
    always @(posedge i_clk) begin
        t_reply_verdict v;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_replies.size() == 0) begin
                $error("unexpected reply result: no verdict pending");
                error_count++;
            end else begin
                v = expected_replies.pop_front();
                replies_seen++;
                if (o_port_match) matches_seen++;
                if (o_truncated) truncs_seen++;
                if (o_port_match !== v.match) begin
                    $error("port_match: expected %0d, got %0d", v.match, o_port_match);
                    error_count++;
                end
                if (o_reply_kind !== v.kind) begin
                    $error("reply_kind: expected %0d, got %0d", v.kind, o_reply_kind);
                    error_count++;
                end
                if (o_icmp_type_seen !== v.typ) begin
                    $error("icmp_type_seen: expected %0d, got %0d", v.typ, o_icmp_type_seen);
                    error_count++;
                end
                if (o_icmp_code_seen !== v.code) begin
                    $error("icmp_code_seen: expected %0d, got %0d", v.code, o_icmp_code_seen);
                    error_count++;
                end
                if (o_truncated !== v.trunc) begin
                    $error("truncated: expected %0d, got %0d", v.trunc, o_truncated);
                    error_count++;
                end
            end
        end
        i_out_stall <= !quiet && ($urandom_range(99) < 21);
    end

    task automatic send_word(input logic [7:0] b, input logic last);
        while (!quiet && $urandom_range(99) < 21) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_rx_byte       <= b;
        i_end_of_packet <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        track_reply_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame[i])
            send_word(frame[i], i == frame.size() - 1);
    endtask

    // drop valid and let the last result drain
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_IP_VERSION_SIX:    cfg_v6 = val[0];
            CFG_PROBE_SOURCE_PORT: cfg_src_port = val;
            CFG_PROBE_DEST_PORT:   cfg_dst_port = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic v6, input logic [15:0] src, input logic [15:0] dst);
        settle();
        write_reg(CFG_IP_VERSION_SIX, {15'd0, v6});
        write_reg(CFG_PROBE_SOURCE_PORT, src);
        write_reg(CFG_PROBE_DEST_PORT, dst);
    endtask

    function automatic void set_byte(input int pos, input logic [7:0] val);
        if (pos < frame.size()) frame[pos] = val;
    endfunction

    function automatic void set_nibble(input int pos, input logic [3:0] nib);
        logic [7:0] tmp;
        if (pos < frame.size()) begin
            tmp = frame[pos];
            frame[pos] = {tmp[7:4], nib};
        end
    endfunction

    // lay out one reply; len <= 0 means complete ports plus a random trailer
    function automatic void form_reply(input logic v6, input logic [3:0] hdr_words,
                                       input logic [3:0] inner_words, input logic [7:0] typ,
                                       input logic [7:0] code, input logic [15:0] src,
                                       input logic [15:0] dst, input int len);
        int ic;
        int us;
        int n;
        ic = v6 ? 0 : 4 * int'(hdr_words);
        us = v6 ? 48 : ic + 8 + 4 * int'(inner_words);
        n  = (len > 0) ? len : us + 4 + $urandom_range(12);
        frame.delete();
        repeat (n) frame.push_back(8'($urandom));
        set_byte(us, src[15:8]);
        set_byte(us + 1, src[7:0]);
        set_byte(us + 2, dst[15:8]);
        set_byte(us + 3, dst[7:0]);
        set_byte(ic, typ);
        set_byte(ic + 1, code);
        if (!v6) begin
            set_nibble(0, hdr_words);
            set_nibble(ic + 8, inner_words);
        end
    endfunction

    function automatic int ports_end(input logic v6, input logic [3:0] hdr_words,
                                     input logic [3:0] inner_words);
        return v6 ? 52 : 4 * int'(hdr_words) + 8 + 4 * int'(inner_words) + 4;
    endfunction

    task automatic test_reset_defaults();
        // reset config: destination 0 wraps to 0xffff
        form_reply(1'b0, 4'd5, 4'd5, TYPE_V4_TIME_EXCEEDED, 8'd0, 16'h0000, 16'hFFFF, 0);
        send_frame();
        frame.delete();
        frame.push_back(8'h45);
        send_frame();
    endtask

    task automatic test_ipv4_kinds();
        apply_settings(1'b0, 16'hFFFF, 16'h0001);
        form_reply(1'b0, 4'd5, 4'd5, TYPE_V4_TIME_EXCEEDED, 8'd0, 16'hFFFF, 16'h0000, 0);
        send_frame();
        form_reply(1'b0, 4'd5, 4'd5, TYPE_V4_UNREACH, CODE_V4_PORT_UNREACH,
                   16'hFFFF, 16'h0000, 0);
        send_frame();
        form_reply(1'b0, 4'd6, 4'd5, TYPE_V4_TIME_EXCEEDED, 8'd1, 16'hFFFF, 16'h0000, 0);
        send_frame();
        form_reply(1'b0, 4'd5, 4'd7, TYPE_V4_UNREACH, 8'd0, 16'hFFFF, 16'h0001, 0);
        send_frame();
        form_reply(1'b0, 4'd5, 4'd5, 8'hFF, 8'hFF, 16'hFFFE, 16'h0000, 0);
        send_frame();
    endtask

    task automatic test_header_lengths();
        apply_settings(1'b0, 16'h8001, 16'h0000);
        // zero nibble: the length byte doubles as the next field
        form_reply(1'b0, 4'd0, 4'd5, 8'h00, 8'h00, 16'h8001, 16'hFFFF, 0);
        send_frame();
        form_reply(1'b0, 4'd5, 4'd0, TYPE_V4_UNREACH, CODE_V4_PORT_UNREACH,
                   16'h8001, 16'hFFFF, 0);
        send_frame();
        form_reply(1'b0, 4'd15, 4'd15, TYPE_V4_TIME_EXCEEDED, 8'd0, 16'h8001, 16'hFFFF, 0);
        send_frame();
        form_reply(1'b0, 4'd1, 4'd1, TYPE_V4_UNREACH, CODE_V4_PORT_UNREACH,
                   16'h8001, 16'hFFFF, 0);
        send_frame();
    endtask

    task automatic test_short_replies();
        int full;
        full = ports_end(1'b0, 4'd5, 4'd5);
        form_reply(1'b0, 4'd5, 4'd5, TYPE_V4_UNREACH, CODE_V4_PORT_UNREACH,
                   16'h8001, 16'hFFFF, full - 1);
        send_frame();
        form_reply(1'b0, 4'd5, 4'd5, TYPE_V4_UNREACH, CODE_V4_PORT_UNREACH,
                   16'h8001, 16'hFFFF, full);
        send_frame();
        form_reply(1'b0, 4'd5, 4'd5, TYPE_V4_TIME_EXCEEDED, 8'd0, 16'h8001, 16'hFFFF, 21);
        send_frame();
        form_reply(1'b0, 4'd5, 4'd5, TYPE_V4_TIME_EXCEEDED, 8'd0, 16'h8001, 16'hFFFF, 1);
        send_frame();
    endtask

    task automatic test_ipv6_kinds();
        apply_settings(1'b1, 16'h1234, 16'h5679);
        form_reply(1'b1, 4'd0, 4'd0, TYPE_V6_TIME_EXCEEDED, 8'd77, 16'h1234, 16'h5678, 0);
        send_frame();
        form_reply(1'b1, 4'd0, 4'd0, TYPE_V6_UNREACH, 8'd4, 16'h1234, 16'h5678, 0);
        send_frame();
        form_reply(1'b1, 4'd0, 4'd0, TYPE_V4_TIME_EXCEEDED, 8'd0, 16'h1234, 16'h5678, 52);
        send_frame();
        form_reply(1'b1, 4'd0, 4'd0, TYPE_V6_UNREACH, 8'd3, 16'h1234, 16'h5678, 30);
        send_frame();
    endtask

    task automatic random_reply();
        logic [3:0]  hw;
        logic [3:0]  iw;
        logic [7:0]  typ;
        logic [7:0]  code;
        logic [15:0] src;
        logic [15:0] dst;
        int          len;
        if ($urandom_range(99) < 25) begin
            // noise
            frame.delete();
            repeat ($urandom_range(80, 1)) frame.push_back(8'($urandom));
        end else begin
            hw = ($urandom_range(3) == 0) ? 4'($urandom) : 4'd5;
            iw = ($urandom_range(3) == 0) ? 4'($urandom) : 4'd5;
            case ($urandom_range(4))
                0: typ = TYPE_V4_TIME_EXCEEDED;
                1: typ = TYPE_V4_UNREACH;
                2: typ = TYPE_V6_UNREACH;
                3: typ = TYPE_V6_TIME_EXCEEDED;
                default: typ = 8'($urandom);
            endcase
            case ($urandom_range(2))
                0: code = 8'd0;
                1: code = CODE_V4_PORT_UNREACH;
                default: code = 8'($urandom);
            endcase
            src = cfg_src_port;
            dst = cfg_dst_port - 16'd1;
            case ($urandom_range(9))
                0: src = src ^ (16'd1 << $urandom_range(15));
                1: dst = dst ^ (16'd1 << $urandom_range(15));
                2: dst = cfg_dst_port;
                3: begin
                    src = 16'($urandom);
                    dst = 16'($urandom);
                end
                default: ;
            endcase
            len = ($urandom_range(4) == 0) ? $urandom_range(ports_end(cfg_v6, hw, iw) - 1, 1)
                                           : 0;
            form_reply(cfg_v6, hw, iw, typ, code, src, dst, len);
        end
        send_frame();
    endtask

    task automatic test_random_traffic();
        int          start_bytes;
        int          n;
        logic        v6;
        logic [15:0] src;
        logic [15:0] dst;
        for (int phase = 0; phase < 4; phase++) begin
            v6  = phase[0];
            src = (phase == 0) ? 16'hFFFF : (phase == 1) ? 16'h0000 : 16'($urandom);
            dst = (phase == 0) ? 16'h0000 : (phase == 1) ? 16'hFFFF : 16'($urandom);
            apply_settings(v6, src, dst);
            quiet = (phase == 2);
            start_bytes = bytes_sent;
            n = 0;
            while (n < 1 || bytes_sent - start_bytes < 30) begin
                random_reply();
                n++;
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        cfg_v6       = 1'b0;
        cfg_src_port = 16'h0000;
        cfg_dst_port = 16'h0000;
        clear_parse();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_ipv4_kinds();
        test_header_lengths();
        test_short_replies();
        test_ipv6_kinds();
        test_random_traffic();

        settle();
        repeat (5) @(posedge i_clk);
        $display("Sent %0d reply bytes; checked %0d results (%0d port matches, %0d truncated)",
                 bytes_sent, replies_seen, matches_seen, truncs_seen);
        $display("Covered IPv4/IPv6 kinds, zero and max header lengths, short replies and noise");
        if (error_count == 0) begin
            $display("icmp_error_reply_matcher_core verification clean");
        end else begin
            $display("icmp_error_reply_matcher_core verification failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("icmp_error_reply_matcher_core verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/iermatch_pkg.sv
sv/iermatch_parse.sv
sv/icmp_error_reply_matcher_core.sv
tb/sv/icmp_error_reply_matcher_core_tb.sv
